>>> hw/rtl/rrhh_pkg.sv
// Shared types, constants and history-table functions for the RRIP replacement block.
`timescale 1ns / 1ps
`default_nettype none
package rrhh_pkg;

  localparam int SETS            = 2048;
  localparam int WAYS            = 16;
  localparam int HISTORY_ENTRIES = 1024;
  localparam int HISTORY_WAYS    = 4;
  localparam int RRPV_MAX        = 3;
  localparam int PSEL_BITS       = 10;

  localparam int SET_W     = $clog2(SETS);
  localparam int WAY_W     = $clog2(WAYS);
  localparam int RRPV_W    = $clog2(RRPV_MAX + 1);
  localparam int HIST_SETS = HISTORY_ENTRIES / HISTORY_WAYS;
  localparam int HSET_W    = $clog2(HIST_SETS);
  localparam int HWAY_W    = (HISTORY_WAYS > 1) ? $clog2(HISTORY_WAYS) : 1;

  localparam int ADDR_W      = 58;
  localparam int CNT_W       = 4;
  localparam int CFG_W       = 11;
  localparam int TICK_W      = 10;
  localparam int TAG_SHIFT   = 12;
  localparam int TAG_W       = 32;
  localparam int HIST_DEPTH  = 4;
  localparam int LEN_W       = 3;
  localparam int REC_W       = 4;
  localparam int RECENCY_MAX = 15;
  localparam int SUM_W       = CNT_W + 2;
  localparam int DIV3_MUL    = 43;   // floor(n/3) == (n*43)>>7 for n < 128
  localparam int DIV3_SHIFT  = 7;
  localparam int PERIOD_MAX  = 1024;

  localparam logic [PSEL_BITS-1:0] PSEL_TOP = {PSEL_BITS{1'b1}};

  // APB register map (word index)
  localparam logic [1:0] REG_BIP_PERIOD  = 2'd0;
  localparam logic [1:0] REG_MAX_HITS    = 2'd1;
  localparam logic [1:0] REG_BIP_LEADER  = 2'd2;
  localparam logic [1:0] REG_SRRIP_LEADER = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [RRPV_W-1:0] rrpv;
  } line_ent_t;

  typedef line_ent_t [WAYS-1:0] line_row_t;

  typedef struct packed {
    logic                              valid;
    logic [TAG_W-1:0]                  tag;
    logic [HIST_DEPTH-1:0][CNT_W-1:0]  counts;
    logic [LEN_W-1:0]                  len;
    logic [REC_W-1:0]                  recency;
  } hist_ent_t;

  typedef hist_ent_t [HISTORY_WAYS-1:0] hist_row_t;

  localparam int LINE_ROW_W = $bits(line_row_t);
  localparam int HIST_ROW_W = $bits(hist_row_t);

  function automatic logic [TAG_W-1:0] hist_tag(logic [ADDR_W-1:0] addr);
    return addr[TAG_SHIFT +: TAG_W];
  endfunction

  function automatic logic [HSET_W-1:0] hist_set(logic [ADDR_W-1:0] addr);
    return addr[HSET_W-1:0];
  endfunction

  // first entry that is invalid or matches the tag, else oldest (lowest index on a tie)
  function automatic logic [HWAY_W-1:0] hist_find(hist_row_t row, logic [TAG_W-1:0] tag);
    logic [HWAY_W-1:0] pick;
    logic [REC_W-1:0]  oldest;
    logic              found;
    pick   = '0;
    oldest = '0;
    found  = 1'b0;
    for (int i = 0; i < HISTORY_WAYS; i++) begin
      if (!found) begin
        if (!row[i].valid || row[i].tag == tag) begin
          pick  = HWAY_W'(i);
          found = 1'b1;
        end else if (row[i].recency > oldest) begin
          oldest = row[i].recency;
          pick   = HWAY_W'(i);
        end
      end
    end
    return pick;
  endfunction

  function automatic logic [CNT_W-1:0] hist_predict(hist_row_t row, logic [TAG_W-1:0] tag,
                                                     logic [CNT_W-1:0] max_hits);
    hist_ent_t              e;
    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       avg;
    logic [SUM_W+DIV3_SHIFT-1:0] prod;
    e    = row[hist_find(row, tag)];
    sum  = '0;
    prod = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (LEN_W'(i) < e.len) sum = sum + SUM_W'(e.counts[i]);
    end
    case (e.len)
      3'd1: avg = sum;
      3'd2: avg = sum >> 1;
      3'd3: begin
        prod = (SUM_W + DIV3_SHIFT)'(sum) * (SUM_W + DIV3_SHIFT)'(DIV3_MUL);
        avg  = SUM_W'(prod >> DIV3_SHIFT);
      end
      3'd4: avg = sum >> 2;
      default: avg = '0;
    endcase
    if (!e.valid || e.tag != tag || e.len == '0) return '0;
    return (avg < SUM_W'(max_hits)) ? avg[CNT_W-1:0] : max_hits;
  endfunction

  function automatic hist_row_t hist_record(hist_row_t row, logic [TAG_W-1:0] tag,
                                            logic [CNT_W-1:0] hits);
    logic [HWAY_W-1:0] idx;
    hist_ent_t         e;
    idx = hist_find(row, tag);
    e   = row[idx];
    if (!e.valid || e.tag != tag) begin
      e.len    = '0;
      e.counts = '0;
    end
    e.valid = 1'b1;
    e.tag   = tag;
    for (int i = 0; i < HISTORY_WAYS; i++) begin
      if (row[i].valid && row[i].recency < REC_W'(RECENCY_MAX))
        row[i].recency = row[i].recency + 1'b1;
    end
    e.recency = '0;
    if (e.len >= LEN_W'(HIST_DEPTH)) begin
      for (int j = 0; j < HIST_DEPTH - 1; j++) e.counts[j] = e.counts[j+1];
      e.len = LEN_W'(HIST_DEPTH - 1);
    end
    e.counts[e.len[1:0]] = hits;
    e.len = e.len + 1'b1;
    row[idx] = e;
    return row;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rrip_replacement_with_hit_history_core.sv
// Top level of the RRIP replacement policy with hit-history insertion.
//
// Usage notes
// - Input channel (in_valid_i / in_stall_o): one transfer per cache event. opcode 0
//   updates a line (write, hit or miss fill); opcode 1 asks for a victim in a set.
// - Output channel (out_valid_o / out_stall_i): exactly one result transfer per input
//   transfer, in order. A finished result sits in an output register, so the next
//   item is taken while the previous result waits.
// - Sequence: an update reads the line and history rows, writes the line row, then
//   loads its result into the output register. A victim request reads the set row
//   once, then each way's history set is read and averaged in turn through the
//   history RAM's single read port, and a valid victim's hit count is written back
//   into the history table; a victim way that is not valid skips that write.
// - Flow: one item at a time; the next item is accepted the cycle after the previous
//   one has its result registered.
// - Reset: control state clears at once; then a clearing pass over all SETS rows
//   zeroes the line and history RAMs, during which in_stall_o stays high. The APB
//   port takes register writes throughout.
// - Output stall: while out_stall_i holds a result in the output register, the next
//   finished item waits in S_FIN, and no further item is accepted until the register is free.
// - Registers are to be changed only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module rrip_replacement_with_hit_history_core
  import rrhh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  input  wire logic [10:0]       set_index_i,
  input  wire logic [3:0]        way_index_i,
  input  wire logic [57:0]       line_addr_i,
  input  wire logic              is_write_i,
  input  wire logic              is_hit_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [3:0]        evict_way_o,
  output logic      [3:0]        predicted_hits_o,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transfer
  localparam logic [2:0] S_UPD  = 3'd1;  // line row and history row in, write line row
  localparam logic [2:0] S_VTOP = 3'd2;  // line row in, find the maximal RRPV
  localparam logic [2:0] S_VRD  = 3'd3;  // read history set of the scanned way
  localparam logic [2:0] S_VEV  = 3'd4;  // predict and compare the scanned way
  localparam logic [2:0] S_RRD  = 3'd5;  // read history set of the victim
  localparam logic [2:0] S_RWR  = 3'd6;  // record the victim's hit count
  localparam logic [2:0] S_FIN  = 3'd7;  // hand the result to the output register

  logic [2:0] state_q, state_d;

  // config registers
  logic [CFG_W-1:0] bip_period_q, bip_leader_q, srrip_leader_q;
  logic [CNT_W-1:0] max_hits_q;

  // item registers
  logic              op_q, wr_q, hit_q;
  logic [SET_W-1:0]  set_q;
  logic [WAY_W-1:0]  way_q;
  logic [ADDR_W-1:0] addr_q;

  // scan state
  logic [WAY_W-1:0]  w_q, w_d, vic_q, vic_d;
  logic [CNT_W:0]    best_q, best_d;
  logic [RRPV_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]  pred_q, pred_d;

  // policy counters
  logic [PSEL_BITS-1:0] psel_q, psel_d;
  logic [TICK_W-1:0]    tick_q, tick_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [WAY_W-1:0] out_vic_q;
  logic [CNT_W-1:0] out_pred_q;
  logic             out_load;

  // clearing pass
  logic             clr_active_q;
  logic [SET_W-1:0] clr_cnt_q;

  // RAM ports
  logic                  line_re, line_we, line_we_m;
  logic [SET_W-1:0]      line_raddr, line_waddr;
  logic [LINE_ROW_W-1:0] line_rdata, line_wdata, line_wdata_m;
  logic                  hist_re, hist_we, hist_we_m;
  logic [HSET_W-1:0]     hist_raddr, hist_waddr, hist_waddr_m;
  logic [HIST_ROW_W-1:0] hist_rdata, hist_wdata, hist_wdata_m;

  line_row_t line_row, new_row;
  hist_row_t hist_row;
  line_ent_t ent;

  logic             in_acc;
  logic             bip_lead, srrip_lead, use_bip, bip_near;
  logic [CFG_W-1:0] period_eff, tick_inc;
  logic [CNT_W-1:0] miss_pred, scan_pred;
  logic [RRPV_W-1:0] bip_rrpv, top_now;
  logic [RRPV_MAX:0] rrpv_seen;

  assign line_row = line_row_t'(line_rdata);
  assign hist_row = hist_row_t'(hist_rdata);

  assign in_stall_o = clr_active_q || (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------- APB ----------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_BIP_PERIOD:   prdata = 32'(bip_period_q);
      REG_MAX_HITS:     prdata = 32'(max_hits_q);
      REG_BIP_LEADER:   prdata = 32'(bip_leader_q);
      REG_SRRIP_LEADER: prdata = 32'(srrip_leader_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_period_q   <= CFG_W'(32);
      max_hits_q     <= CNT_W'(3);
      bip_leader_q   <= CFG_W'(0);
      srrip_leader_q <= CFG_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_BIP_PERIOD:   bip_period_q   <= pwdata[CFG_W-1:0];
        REG_MAX_HITS:     max_hits_q     <= pwdata[CNT_W-1:0];
        REG_BIP_LEADER:   bip_leader_q   <= pwdata[CFG_W-1:0];
        REG_SRRIP_LEADER: srrip_leader_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- insertion policy ----------------
  assign bip_lead   = (CFG_W'(set_q) == bip_leader_q);
  assign srrip_lead = !bip_lead && (CFG_W'(set_q) == srrip_leader_q);
  assign use_bip    = bip_lead || (!srrip_lead && (psel_q > (PSEL_TOP >> 1)));

  always_comb begin
    if (bip_period_q == '0) period_eff = CFG_W'(1);
    else if (bip_period_q > CFG_W'(PERIOD_MAX)) period_eff = CFG_W'(PERIOD_MAX);
    else period_eff = bip_period_q;
  end

  assign tick_inc = CFG_W'(tick_q) + 1'b1;
  assign bip_near = (tick_inc >= period_eff);
  assign bip_rrpv = bip_near ? RRPV_W'(RRPV_MAX - 1) : RRPV_W'(RRPV_MAX);

  assign miss_pred = hist_predict(hist_row, hist_tag(addr_q), max_hits_q);
  assign scan_pred = hist_predict(hist_row, hist_tag(line_row[w_q].addr), max_hits_q);

  // highest RRPV present in the set: presence flags, then priority
  always_comb begin
    rrpv_seen = '0;
    for (int i = 0; i < WAYS; i++) rrpv_seen[line_row[i].rrpv] = 1'b1;
    top_now = '0;
    for (int k = 0; k <= RRPV_MAX; k++) if (rrpv_seen[k]) top_now = RRPV_W'(k);
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    vic_d      = vic_q;
    best_d     = best_q;
    top_d      = top_q;
    pred_d     = pred_q;
    psel_d     = psel_q;
    tick_d     = tick_q;
    line_re    = 1'b0;
    line_raddr = set_index_i[SET_W-1:0];
    line_we    = 1'b0;
    line_wdata = line_rdata;
    hist_re    = 1'b0;
    hist_raddr = hist_set(line_addr_i);
    hist_we    = 1'b0;
    hist_waddr = hist_set(line_row[vic_q].addr);
    hist_wdata = hist_rdata;
    ent        = line_row[way_q];
    new_row    = line_row;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          line_re = 1'b1;
          hist_re = 1'b1;
          vic_d   = '0;
          pred_d  = '0;
          state_d = opcode_i ? S_VTOP : S_UPD;
        end
      end
      S_UPD: begin
        ent.valid = 1'b1;
        ent.addr  = addr_q;
        if (wr_q) begin
          ent.rrpv = RRPV_W'(RRPV_MAX - 1);
        end else if (hit_q) begin
          if (ent.cnt < max_hits_q) ent.cnt = ent.cnt + 1'b1;
          ent.rrpv = '0;
        end else begin
          ent.cnt = '0;
          pred_d  = miss_pred;
          if (miss_pred == '0) begin
            if (use_bip) begin
              ent.rrpv = bip_rrpv;
              tick_d   = bip_near ? '0 : tick_inc[TICK_W-1:0];
            end else begin
              ent.rrpv = RRPV_W'(RRPV_MAX - 1);
            end
          end else if (miss_pred >= CNT_W'(RRPV_MAX)) begin
            ent.rrpv = '0;
          end else begin
            ent.rrpv = RRPV_W'(RRPV_MAX - int'(miss_pred));
          end
          if (bip_lead && psel_q != '0) psel_d = psel_q - 1'b1;
          else if (srrip_lead && psel_q != PSEL_TOP) psel_d = psel_q + 1'b1;
        end
        new_row[way_q] = ent;
        line_we    = 1'b1;
        line_wdata = new_row;
        state_d    = S_FIN;
      end
      S_VTOP: begin
        top_d   = top_now;
        w_d     = '0;
        vic_d   = '0;
        best_d  = {1'b0, max_hits_q} + 1'b1;
        state_d = S_VRD;
      end
      S_VRD: begin
        hist_re    = 1'b1;
        hist_raddr = hist_set(line_row[w_q].addr);
        state_d    = S_VEV;
      end
      S_VEV: begin
        if (line_row[w_q].rrpv == top_q && {1'b0, scan_pred} < best_q) begin
          best_d = {1'b0, scan_pred};
          vic_d  = w_q;
        end
        if (w_q == WAY_W'(WAYS - 1)) begin
          state_d = S_RRD;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_RRD: begin
        pred_d = best_q[CNT_W-1:0];
        if (line_row[vic_q].valid) begin
          hist_re    = 1'b1;
          hist_raddr = hist_set(line_row[vic_q].addr);
          state_d    = S_RWR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RWR: begin
        hist_we    = 1'b1;
        hist_wdata = hist_record(hist_row, hist_tag(line_row[vic_q].addr), line_row[vic_q].cnt);
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      psel_q       <= '0;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      psel_q      <= psel_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == SET_W'(SETS - 1)) clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= opcode_i;
      set_q  <= set_index_i[SET_W-1:0];
      way_q  <= way_index_i[WAY_W-1:0];
      addr_q <= line_addr_i;
      wr_q   <= is_write_i;
      hit_q  <= is_hit_i;
    end
    w_q    <= w_d;
    vic_q  <= vic_d;
    best_q <= best_d;
    top_q  <= top_d;
    pred_q <= pred_d;
    if (out_load) begin
      out_vic_q  <= op_q ? vic_q : '0;
      out_pred_q <= pred_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign evict_way_o      = out_vic_q;
  assign predicted_hits_o = out_pred_q;

  // ---------------- memories ----------------
  // clearing pass owns the write ports until it finishes
  assign line_we_m    = clr_active_q || line_we;
  assign line_waddr   = clr_active_q ? clr_cnt_q : set_q;
  assign line_wdata_m = clr_active_q ? '0 : line_wdata;
  assign hist_we_m    = clr_active_q || hist_we;
  assign hist_waddr_m = clr_active_q ? clr_cnt_q[HSET_W-1:0] : hist_waddr;
  assign hist_wdata_m = clr_active_q ? '0 : hist_wdata;

  rrhh_ram #(.WIDTH(LINE_ROW_W), .DEPTH(SETS)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we_m),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata_m),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  rrhh_ram #(.WIDTH(HIST_ROW_W), .DEPTH(HIST_SETS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we_m),
    .waddr_i (hist_waddr_m),
    .wdata_i (hist_wdata_m),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // ---------------- assertions ----------------
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> in_stall_o) else $error("item taken during clearing pass");

  a_victim_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i) |=> (state_q == S_VTOP)) else $error("victim request misrouted");

  a_scan_no_line_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VEV || state_q == S_VRD) |-> !line_we) else $error("line write in scan");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && out_stall_i) |=> (state_q == S_FIN))
    else $error("result overwrote a held transfer");

endmodule
`default_nettype wire

>>> hw/rtl/rrhh_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rrhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
